// ----- sv/pbre_pkg.sv -----
// ----------------------------------------------------------------------------
// pbre_pkg: shared types and constants of the base relocation engine
// Result record, kind and error codes, phase and register index encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package pbre_pkg;

    localparam int WORD_W    = 16;
    localparam int ADDR_W    = 32;
    localparam int ADJ_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int KIND_W    = 3;
    localparam int ERR_W     = 3;
    localparam int OUT_PAD_W = 5;
    localparam int OUT_W     = ADDR_W + ADJ_W + ERR_W + OUT_PAD_W;

    // result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    // smallest legal block: the header alone
    localparam logic [ADDR_W-1:0] MIN_BLOCK = 32'd8;
    localparam logic [ADDR_W-1:0] WORD_BYTES = 32'd2;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_HDR   = 2'd1,
        PH_ENT   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        HS_PAGE_LO = 2'd0,
        HS_PAGE_HI = 2'd1,
        HS_SIZE_LO = 2'd2,
        HS_SIZE_HI = 2'd3
    } t_hdr_slot;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIGH16 = 3'd0,
        KIND_LOW16  = 3'd1,
        KIND_ADD32  = 3'd2,
        KIND_ADD64  = 3'd3,
        KIND_DONE   = 3'd4,
        KIND_ERROR  = 3'd5
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE          = 3'd0,
        ERR_TABLE_OUTSIDE = 3'd1,
        ERR_BAD_SIZE      = 3'd2,
        ERR_SIZE_OVER_DIR = 3'd3,
        ERR_BLOCK_BEYOND  = 3'd4,
        ERR_BAD_PAGE      = 3'd5,
        ERR_UNKNOWN_TYPE  = 3'd6,
        ERR_TRUNCATED     = 3'd7
    } t_err;

    typedef enum logic [3:0] {
        RT_ABSOLUTE = 4'd0,
        RT_HIGH     = 4'd1,
        RT_LOW      = 4'd2,
        RT_HIGHLOW  = 4'd3,
        RT_DIR64    = 4'd10
    } t_rtype;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADJUST       = 3'd0,
        CFG_IMAGE_SIZE   = 3'd1,
        CFG_TABLE_OFFSET = 3'd2,
        CFG_TABLE_SIZE   = 3'd3,
        CFG_DIR_SIZE     = 3'd4
    } t_cfg_idx;

    // addend is rebuilt from kind and adjust at the output
    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] target;
        t_err              err;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/pe_base_relocation_engine_unit.sv -----
// ----------------------------------------------------------------------------
// pe_base_relocation_engine_unit: base relocation table walker
// Walks the relocation table word by word and emits patch add commands,
// ending each run with a done or error beat.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                   tuser  tlast
//  s_axis    in   [15:0] word                             -      end_of_data
//  m_axis    out  [31:0] target_offset, [95:32] addend,   kind   last_of_run
//                 [98:96] error_code, [103:99] zero
//  cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data, write only
//
//  One table word per cycle while s_axis does not stall. A word is registered
//  on entry and decoded from the input register into zero, one or two result
//  records in a four-deep result queue whose head drives m_axis. A word that
//  yields two beats (an add plus done or truncation error) gives them to m_axis
//  one after the other; s_axis stalls while a word waits in the input register
//  and the queue has fewer than two free slots. Synchronous active-low reset
//  clears the configuration, input valid flag, walker state and queue pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module pe_base_relocation_engine_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // cfg write port
    input  wire logic                                  i_cfg_we,
    input  wire logic [pbre_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [pbre_pkg::ADJ_W-1:0]            i_cfg_data,
    // table words
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [pbre_pkg::WORD_W-1:0]           s_axis_tdata,  // [15:0] word
    input  wire logic                                  s_axis_tlast,  // end_of_data
    // results
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [31:0] target_offset, [95:32] addend, [98:96] error_code, [103:99] zero
    output logic [pbre_pkg::OUT_W-1:0]                 m_axis_tdata,
    output logic [pbre_pkg::KIND_W-1:0]                m_axis_tuser,  // [2:0] kind
    output logic                                       m_axis_tlast   // last_of_run
);

    // configuration
    logic [pbre_pkg::ADJ_W-1:0]  r_adjust;
    logic [pbre_pkg::ADDR_W-1:0] r_image_size;
    logic [pbre_pkg::ADDR_W-1:0] r_table_offset;
    logic [pbre_pkg::ADDR_W-1:0] r_table_size;
    logic [pbre_pkg::ADDR_W-1:0] r_dir_size;

    // input register
    logic                         r_in_valid;
    logic [pbre_pkg::WORD_W-1:0]  r_in_word;
    logic                         r_in_eod;

    // walker state (r_off = position - block_start)
    pbre_pkg::t_phase             r_phase;
    logic [pbre_pkg::ADDR_W-1:0]  r_off;
    logic [pbre_pkg::ADDR_W-1:0]  r_blk_start;
    logic [pbre_pkg::ADDR_W-1:0]  r_page;
    logic [pbre_pkg::ADDR_W-1:0]  r_blk_size;
    logic                         r_ended;

    pbre_pkg::t_phase             n_phase;
    logic [pbre_pkg::ADDR_W-1:0]  n_off;
    logic [pbre_pkg::ADDR_W-1:0]  n_blk_start;
    logic [pbre_pkg::ADDR_W-1:0]  n_page;
    logic [pbre_pkg::ADDR_W-1:0]  n_blk_size;
    logic                         n_ended;

    logic                         w_in_fire;
    logic                         w_proc_fire;
    logic                         w_room2;
    logic                         w_q_valid;
    pbre_pkg::t_result            w_head;
    pbre_pkg::t_result            w_res0;
    pbre_pkg::t_result            w_res1;
    logic [1:0]                   w_cnt;
    logic [1:0]                   w_push_cnt;
    logic [pbre_pkg::ADJ_W-1:0]   w_addend;

    assign s_axis_tready = !r_in_valid || w_room2;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_proc_fire   = r_in_valid && w_room2;
    assign w_push_cnt    = w_proc_fire ? w_cnt : 2'd0;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adjust       <= '0;
            r_image_size   <= '0;
            r_table_offset <= '0;
            r_table_size   <= '0;
            r_dir_size     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pbre_pkg::CFG_ADJUST:       r_adjust       <= i_cfg_data;
                pbre_pkg::CFG_IMAGE_SIZE:   r_image_size   <= i_cfg_data[pbre_pkg::ADDR_W-1:0];
                pbre_pkg::CFG_TABLE_OFFSET: r_table_offset <= i_cfg_data[pbre_pkg::ADDR_W-1:0];
                pbre_pkg::CFG_TABLE_SIZE:   r_table_size   <= i_cfg_data[pbre_pkg::ADDR_W-1:0];
                pbre_pkg::CFG_DIR_SIZE:     r_dir_size     <= i_cfg_data[pbre_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_word <= s_axis_tdata;
            r_in_eod  <= s_axis_tlast;
        end
    end

    // ---------------- word decode ----------------
    always_comb begin
        logic [pbre_pkg::ADDR_W-1:0]   v_tend;
        logic [pbre_pkg::ADDR_W-1:0]   v_bsz;
        logic [pbre_pkg::ADDR_W-1:0]   v_off;
        logic [pbre_pkg::ADDR_W-1:0]   v_target;
        logic [pbre_pkg::ADDR_W:0]     v_next;
        logic [pbre_pkg::ADDR_W+1:0]   v_span;
        logic                          v_bad_b;
        logic                          v_bad_e;
        pbre_pkg::t_phase              v_phase;
        logic                          v_end;
        pbre_pkg::t_err                v_code;
        logic                          v_add;
        pbre_pkg::t_kind               v_add_kind;
        logic                          v_close;
        pbre_pkg::t_result             v_res_add;
        pbre_pkg::t_result             v_res_end;

        n_phase     = r_phase;
        n_off       = r_off;
        n_blk_start = r_blk_start;
        n_page      = r_page;
        n_blk_size  = r_blk_size;
        n_ended     = r_ended;

        v_tend     = r_table_offset + r_table_size;
        v_bad_b    = (r_table_offset > r_image_size);
        v_bad_e    = (v_tend > r_image_size);
        v_bsz      = {r_in_word, r_blk_size[pbre_pkg::WORD_W-1:0]};
        v_span     = {2'b00, r_table_offset} + {2'b00, r_blk_start} + {2'b00, v_bsz};
        v_off      = r_off + pbre_pkg::WORD_BYTES;
        v_target   = r_page + {20'd0, r_in_word[11:0]};
        v_next     = '0;
        v_phase    = r_phase;
        v_end      = 1'b0;
        v_code     = pbre_pkg::ERR_NONE;
        v_add      = 1'b0;
        v_add_kind = pbre_pkg::KIND_HIGH16;
        v_close    = 1'b0;

        if (!r_ended) begin
            // bounds and trivial-run checks on the first word of a run
            if (v_phase == pbre_pkg::PH_START) begin
                priority if (v_bad_b && v_bad_e) begin
                    v_end = 1'b1;
                end else if (v_bad_b || v_bad_e) begin
                    v_end  = 1'b1;
                    v_code = pbre_pkg::ERR_TABLE_OUTSIDE;
                end else if (r_adjust == '0 || r_table_size == '0) begin
                    v_end = 1'b1;
                end else begin
                    v_phase = pbre_pkg::PH_HDR;
                    n_phase = pbre_pkg::PH_HDR;
                end
            end

            if (!v_end) begin
                if (v_phase == pbre_pkg::PH_HDR) begin
                    n_off = v_off;
                    unique case (pbre_pkg::t_hdr_slot'(r_off[2:1]))
                        pbre_pkg::HS_PAGE_LO: n_page = {16'd0, r_in_word};
                        pbre_pkg::HS_PAGE_HI: n_page = {r_in_word, r_page[15:0]};
                        pbre_pkg::HS_SIZE_LO: n_blk_size = {16'd0, r_in_word};
                        pbre_pkg::HS_SIZE_HI: begin
                            n_blk_size = v_bsz;
                            priority if (v_bsz < pbre_pkg::MIN_BLOCK || v_bsz[0]) begin
                                v_end  = 1'b1;
                                v_code = pbre_pkg::ERR_BAD_SIZE;
                            end else if (v_bsz > r_dir_size) begin
                                v_end  = 1'b1;
                                v_code = pbre_pkg::ERR_SIZE_OVER_DIR;
                            end else if (v_span > {2'b00, r_image_size}) begin
                                v_end  = 1'b1;
                                v_code = pbre_pkg::ERR_BLOCK_BEYOND;
                            end else if (r_page > r_image_size) begin
                                v_end  = 1'b1;
                                v_code = pbre_pkg::ERR_BAD_PAGE;
                            end else begin
                                n_phase = pbre_pkg::PH_ENT;
                                v_close = (v_bsz == pbre_pkg::MIN_BLOCK);
                            end
                        end
                        default: ;
                    endcase
                end else begin
                    unique case (r_in_word[15:12])
                        pbre_pkg::RT_ABSOLUTE: ;
                        pbre_pkg::RT_HIGH: begin
                            v_add      = 1'b1;
                            v_add_kind = pbre_pkg::KIND_HIGH16;
                        end
                        pbre_pkg::RT_LOW: begin
                            v_add      = 1'b1;
                            v_add_kind = pbre_pkg::KIND_LOW16;
                        end
                        pbre_pkg::RT_HIGHLOW: begin
                            v_add      = 1'b1;
                            v_add_kind = pbre_pkg::KIND_ADD32;
                        end
                        pbre_pkg::RT_DIR64: begin
                            v_add      = 1'b1;
                            v_add_kind = pbre_pkg::KIND_ADD64;
                        end
                        default: begin
                            v_end  = 1'b1;
                            v_code = pbre_pkg::ERR_UNKNOWN_TYPE;
                        end
                    endcase
                    if (!v_end) begin
                        n_off   = v_off;
                        v_close = (v_off >= r_blk_size);
                    end
                end
            end

            // block finished: either the table is done or the next header follows
            if (v_close) begin
                v_next = {1'b0, r_blk_start} + {1'b0, n_blk_size};
                if (v_next >= {1'b0, r_table_size}) begin
                    v_end = 1'b1;
                end else begin
                    n_blk_start = v_next[pbre_pkg::ADDR_W-1:0];
                    n_off       = '0;
                    n_phase     = pbre_pkg::PH_HDR;
                end
            end

            if (v_end) begin
                n_ended = 1'b1;
            end else if (r_in_eod) begin
                v_end  = 1'b1;
                v_code = pbre_pkg::ERR_TRUNCATED;
            end
        end

        // last word from the feeder rearms for a new run
        if (r_in_eod) begin
            n_phase     = pbre_pkg::PH_START;
            n_off       = '0;
            n_blk_start = '0;
            n_page      = '0;
            n_blk_size  = '0;
            n_ended     = 1'b0;
        end

        v_res_add.kind   = v_add_kind;
        v_res_add.target = v_target;
        v_res_add.err    = pbre_pkg::ERR_NONE;
        v_res_end.kind   = (v_code == pbre_pkg::ERR_NONE) ? pbre_pkg::KIND_DONE
                                                          : pbre_pkg::KIND_ERROR;
        v_res_end.target = '0;
        v_res_end.err    = v_code;

        w_res0 = v_add ? v_res_add : v_res_end;
        w_res1 = v_res_end;
        w_cnt  = {v_add & v_end, v_add ^ v_end};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pbre_pkg::PH_START;
            r_off       <= '0;
            r_blk_start <= '0;
            r_page      <= '0;
            r_blk_size  <= '0;
            r_ended     <= 1'b0;
        end else if (w_proc_fire) begin
            r_phase     <= n_phase;
            r_off       <= n_off;
            r_blk_start <= n_blk_start;
            r_page      <= n_page;
            r_blk_size  <= n_blk_size;
            r_ended     <= n_ended;
        end
    end

    // ---------------- result queue ----------------
    pbre_res_queue u_res_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_res0     (w_res0),
        .i_res1     (w_res1),
        .o_room2    (w_room2),
        .o_valid    (w_q_valid),
        .o_head     (w_head),
        .i_pop      (m_axis_tready)
    );

    // user holds adjust stable in a run (unenforced), so addend is cut from kind
    always_comb begin
        unique case (w_head.kind)
            pbre_pkg::KIND_HIGH16: w_addend = {48'd0, r_adjust[31:16]};
            pbre_pkg::KIND_LOW16:  w_addend = {48'd0, r_adjust[15:0]};
            pbre_pkg::KIND_ADD32:  w_addend = {32'd0, r_adjust[31:0]};
            pbre_pkg::KIND_ADD64:  w_addend = r_adjust;
            default:               w_addend = '0;
        endcase
    end

    assign m_axis_tvalid = w_q_valid;
    assign m_axis_tdata  = {{pbre_pkg::OUT_PAD_W{1'b0}}, w_head.err, w_addend, w_head.target};
    assign m_axis_tuser  = w_head.kind;
    assign m_axis_tlast  = (w_head.kind == pbre_pkg::KIND_DONE) ||
                           (w_head.kind == pbre_pkg::KIND_ERROR);

endmodule

`default_nettype wire

// ----- sv/pbre_res_queue.sv -----
// ----------------------------------------------------------------------------
// pbre_res_queue: result queue
// Small FIFO of result records; takes up to two records per cycle, gives one while popped.
// ----------------------------------------------------------------------------
`default_nettype none

module pbre_res_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [1:0]        i_push_cnt,
    input  wire pbre_pkg::t_result i_res0,
    input  wire pbre_pkg::t_result i_res1,
    output logic                   o_room2,
    output logic                   o_valid,
    output pbre_pkg::t_result      o_head,
    input  wire logic              i_pop
);

    pbre_pkg::t_result              r_mem [pbre_pkg::RQ_DEPTH];
    logic [pbre_pkg::RQ_AW-1:0]     r_wr;
    logic [pbre_pkg::RQ_AW-1:0]     r_rd;
    logic [pbre_pkg::RQ_AW:0]       r_count;
    logic [pbre_pkg::RQ_AW-1:0]     n_wr;
    logic [pbre_pkg::RQ_AW-1:0]     n_rd;
    logic [pbre_pkg::RQ_AW:0]       n_count;
    logic [pbre_pkg::RQ_AW-1:0]     w_wr1;
    logic                           w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign w_wr1   = r_wr + pbre_pkg::RQ_AW'(1);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign o_room2 = (r_count <= (pbre_pkg::RQ_AW+1)'(pbre_pkg::RQ_DEPTH - 2));

    always_comb begin
        n_wr    = r_wr + pbre_pkg::RQ_AW'(i_push_cnt);
        n_rd    = r_rd + pbre_pkg::RQ_AW'(w_pop);
        n_count = r_count + (pbre_pkg::RQ_AW+1)'(i_push_cnt)
                  - (pbre_pkg::RQ_AW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[w_wr1] <= i_res1;
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the base relocation engine
// Feeds relocation tables word by word, predicts every add command and the
// done or error beat that closes each run, and compares them with m_axis.
// ----------------------------------------------------------------------------
module tb_top;
    import pbre_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        t_kind             kind;
        logic [ADDR_W-1:0] target;
        logic [ADJ_W-1:0]  addend;
        t_err              err;
        bit                last;
    } t_fixup;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [ADJ_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [WORD_W-1:0]    s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic [KIND_W-1:0]    m_axis_tuser;
    logic                 m_axis_tlast;

    // predictor copy of the registers and walk state
    logic [ADJ_W-1:0]  r_adjust;
    logic [ADDR_W-1:0] r_image, r_toff, r_tsize, r_dir;
    t_phase            w_phase;
    logic [ADDR_W-1:0] w_pos, w_blk, w_page, w_bsize;
    bit                w_ended;

    t_fixup      fixup_q[$];
    logic [15:0] tw_q[$];
    bit          te_q[$];
    int          lay_ent[$];

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int hold_reqs  = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int idle_cycles = 0;
    int n_fail = 0, n_words = 0, n_beats = 0, n_settings = 0;
    int kind_seen[8];

    pe_base_relocation_engine_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [15:0] word
        .s_axis_tlast  (s_axis_tlast),   // end_of_data
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [31:0] target_offset, [95:32] addend, [98:96] error_code, [103:99] zero
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),   // [2:0] kind
        .m_axis_tlast  (m_axis_tlast)    // last_of_run
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic void push_fix(t_kind k, logic [ADDR_W-1:0] tgt,
                                     logic [ADJ_W-1:0] add, t_err e, bit last);
        t_fixup f;
        f.kind = k; f.target = tgt; f.addend = add; f.err = e; f.last = last;
        fixup_q.push_back(f);
    endfunction

    function automatic void finish_run(t_err e);
        if (e == ERR_NONE) push_fix(KIND_DONE, '0, '0, ERR_NONE, 1'b1);
        else push_fix(KIND_ERROR, '0, '0, e, 1'b1);
        w_ended = 1'b1;
    endfunction

    function automatic void rearm();
        w_phase = PH_START;
        w_pos = '0; w_blk = '0; w_page = '0; w_bsize = '0;
        w_ended = 1'b0;
    endfunction

    function automatic void close_blk();
        logic [ADDR_W:0] nxt;
        nxt = {1'b0, w_blk} + {1'b0, w_bsize};
        if (nxt >= {1'b0, r_tsize}) begin
            finish_run(ERR_NONE);
        end else begin
            w_blk = nxt[ADDR_W-1:0];
            w_pos = nxt[ADDR_W-1:0];
            w_phase = PH_HDR;
        end
    endfunction

    function automatic void header_word(logic [15:0] w);
        logic [ADDR_W-1:0] off;
        logic [ADDR_W+1:0] reach;
        off = w_pos - w_blk;
        case (t_hdr_slot'(off[2:1]))
            HS_PAGE_LO: w_page = {16'h0, w};
            HS_PAGE_HI: w_page = w_page | {w, 16'h0};
            HS_SIZE_LO: w_bsize = {16'h0, w};
            default:    w_bsize = w_bsize | {w, 16'h0};
        endcase
        w_pos = w_pos + WORD_BYTES;
        if (off < 6) return;
        reach = {2'b0, r_toff} + {2'b0, w_blk} + {2'b0, w_bsize};
        if (w_bsize < MIN_BLOCK || w_bsize[0]) finish_run(ERR_BAD_SIZE);
        else if (w_bsize > r_dir) finish_run(ERR_SIZE_OVER_DIR);
        else if (reach > {2'b0, r_image}) finish_run(ERR_BLOCK_BEYOND);
        else if (w_page > r_image) finish_run(ERR_BAD_PAGE);
        else begin
            w_phase = PH_ENT;
            if (w_bsize == MIN_BLOCK) close_blk();
        end
    endfunction

    function automatic void entry_word(logic [15:0] w);
        logic [ADDR_W-1:0] tgt;
        tgt = w_page + {20'h0, w[11:0]};
        case (w[15:12])
            RT_ABSOLUTE: ;
            RT_HIGH:     push_fix(KIND_HIGH16, tgt, {48'h0, r_adjust[31:16]}, ERR_NONE, 1'b0);
            RT_LOW:      push_fix(KIND_LOW16, tgt, {48'h0, r_adjust[15:0]}, ERR_NONE, 1'b0);
            RT_HIGHLOW:  push_fix(KIND_ADD32, tgt, {32'h0, r_adjust[31:0]}, ERR_NONE, 1'b0);
            RT_DIR64:    push_fix(KIND_ADD64, tgt, r_adjust, ERR_NONE, 1'b0);
            default: begin
                finish_run(ERR_UNKNOWN_TYPE);
                return;
            end
        endcase
        w_pos = w_pos + WORD_BYTES;
        if (w_pos - w_blk >= w_bsize) close_blk();
    endfunction

    function automatic void apply_word(logic [15:0] w, bit eod);
        logic [ADDR_W-1:0] tend;
        bit bad_b, bad_e;
        if (w_ended) begin
            if (eod) rearm();
            return;
        end
        if (w_phase == PH_START) begin
            tend  = r_toff + r_tsize;
            bad_b = r_toff > r_image;
            bad_e = tend > r_image;
            if (bad_b && bad_e) finish_run(ERR_NONE);
            else if (bad_b || bad_e) finish_run(ERR_TABLE_OUTSIDE);
            else if (r_adjust == '0 || r_tsize == '0) finish_run(ERR_NONE);
            else w_phase = PH_HDR;
        end
        if (!w_ended) begin
            if (w_phase == PH_HDR) header_word(w);
            else entry_word(w);
        end
        if (eod) begin
            if (!w_ended) push_fix(KIND_ERROR, '0, '0, ERR_TRUNCATED, 1'b1);
            rearm();
        end
    endfunction

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin : chk
        t_fixup want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_beats++;
            kind_seen[m_axis_tuser]++;
            if (fixup_q.size() == 0) begin
                n_fail++;
                $error("unexpected result beat: kind %0d", m_axis_tuser);
            end else begin
                want = fixup_q.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    n_fail++;
                    $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                end
                if (m_axis_tdata[31:0] !== want.target) begin
                    n_fail++;
                    $error("target_offset: expected %h, got %h", want.target,
                           m_axis_tdata[31:0]);
                end
                if (m_axis_tdata[95:32] !== want.addend) begin
                    n_fail++;
                    $error("addend: expected %h, got %h", want.addend, m_axis_tdata[95:32]);
                end
                if (m_axis_tdata[98:96] !== want.err) begin
                    n_fail++;
                    $error("error_code: expected %0d, got %0d", want.err,
                           m_axis_tdata[98:96]);
                end
                if (m_axis_tlast !== want.last) begin
                    n_fail++;
                    $error("last_of_run: expected %0d, got %0d", want.last, m_axis_tlast);
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_en) begin
            m_axis_tready <= ($urandom_range(99, 0) >= 30);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog: no beat on any port for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress in %0d cycles, %0d results pending",
                     STALL_LIMIT, fixup_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- drivers ----------------
    task automatic cfg_write(input t_cfg_idx idx, input logic [ADJ_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_ADJUST:       r_adjust = val;
            CFG_IMAGE_SIZE:   r_image  = val[ADDR_W-1:0];
            CFG_TABLE_OFFSET: r_toff   = val[ADDR_W-1:0];
            CFG_TABLE_SIZE:   r_tsize  = val[ADDR_W-1:0];
            default:          r_dir    = val[ADDR_W-1:0];
        endcase
    endtask

    task automatic set_regs(input logic [ADJ_W-1:0] adj, input logic [ADDR_W-1:0] img,
                            input logic [ADDR_W-1:0] toff, input logic [ADDR_W-1:0] tsz,
                            input logic [ADDR_W-1:0] dir);
        cfg_write(CFG_ADJUST, adj);
        cfg_write(CFG_IMAGE_SIZE, {32'h0, img});
        cfg_write(CFG_TABLE_OFFSET, {32'h0, toff});
        cfg_write(CFG_TABLE_SIZE, {32'h0, tsz});
        cfg_write(CFG_DIR_SIZE, {32'h0, dir});
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic send_word(input logic [15:0] w, input bit eod);
        while (tx_idle_en && $urandom_range(99, 0) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tlast  <= eod;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_word(w, eod);
        n_words++;
    endtask

    task automatic send_run();
        foreach (tw_q[i]) send_word(tw_q[i], te_q[i]);
    endtask

    // stop sending, wait for every pending result, then let the pipe empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (fixup_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // ---------------- table generation ----------------
    function automatic logic [3:0] entry_type(bit noisy);
        if (noisy && $urandom_range(99, 0) < 3) return 4'($urandom_range(15, 0));
        case ($urandom_range(4, 0))
            0:       return RT_ABSOLUTE;
            1:       return RT_HIGH;
            2:       return RT_LOW;
            3:       return RT_HIGHLOW;
            default: return RT_DIR64;
        endcase
    endfunction

    // one run of the current layout; noisy runs may be damaged on purpose
    function automatic void build_run(bit noisy);
        logic [ADDR_W-1:0] page, bsz;
        logic [11:0]       ofs;
        int                cut;
        tw_q.delete();
        te_q.delete();
        foreach (lay_ent[b]) begin
            page = $urandom_range(r_image, 0);
            bsz  = MIN_BLOCK + WORD_BYTES * lay_ent[b];
            tw_q.push_back(page[15:0]);
            tw_q.push_back(page[31:16]);
            tw_q.push_back(bsz[15:0]);
            tw_q.push_back(bsz[31:16]);
            repeat (lay_ent[b]) begin
                ofs = 12'($urandom_range(4095, 0));
                tw_q.push_back({entry_type(noisy), ofs});
            end
        end
        if (noisy && $urandom_range(99, 0) < 25) begin
            case ($urandom_range(4, 0))
                0: tw_q[$urandom_range(tw_q.size() - 1, 0)] = 16'($urandom_range(65535, 0));
                1: begin
                    cut = $urandom_range(tw_q.size(), 1);
                    while (tw_q.size() > cut) void'(tw_q.pop_back());
                end
                2: repeat ($urandom_range(3, 1)) tw_q.push_back(16'($urandom_range(65535, 0)));
                3: tw_q[2] = $urandom_range(1, 0) ? 16'($urandom_range(9, 0))
                                                  : 16'($urandom_range(65535, 0));
                default: tw_q[1] = 16'($urandom_range(65535, 0));
            endcase
        end
        foreach (tw_q[i]) te_q.push_back(i == tw_q.size() - 1);
    endfunction

    // ---------------- tests ----------------
    task automatic test_run_start();
        send_word(16'h0000, 1'b1);           // reset registers: zero adjust
        settle();
        set_regs(64'h1, 32'h10, 32'h20, 32'h0, '1);
        send_word(16'h1234, 1'b1);           // both ends outside the image
        settle();
        set_regs(64'h1, 32'h10, 32'h8, 32'h10, '1);
        send_word(16'h0000, 1'b0);           // table end outside
        send_word(16'hFFFF, 1'b1);
        settle();
        set_regs(64'h1, 32'h10, 32'h8, 32'h0, '1);
        send_word(16'h0001, 1'b1);           // empty table
        settle();
    endtask

    task automatic test_full_table();
        set_regs('1, '1, 32'h0, 32'd26, '1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'd18, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word({RT_ABSOLUTE, 12'h123}, 1'b0);
        send_word({RT_HIGH, 12'hFFF}, 1'b0);  // page + offset wraps
        send_word({RT_LOW, 12'h000}, 1'b0);
        send_word({RT_HIGHLOW, 12'h800}, 1'b0);
        send_word({RT_DIR64, 12'h001}, 1'b0);
        // header-only block that reaches the table end
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'd8, 1'b0);
        send_word(16'h0000, 1'b1);
        settle();
    endtask

    task automatic test_block_errors();
        set_regs(64'h0123_4567_89AB_CDEF, 32'h1000, 32'hFE0, 32'h20, 32'h40);
        send_word(16'h0000, 1'b0);           // odd size below a header
        send_word(16'h0000, 1'b0);
        send_word(16'd7, 1'b0);
        send_word(16'h0000, 1'b1);
        send_word(16'h0000, 1'b0);           // unknown entry type
        send_word(16'h0000, 1'b0);
        send_word(16'd10, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word({4'h4, 12'h000}, 1'b0);
        send_word(16'hFFFF, 1'b1);           // ignored, rearms
        send_word(16'h0100, 1'b1);           // table cut short
        settle();
    endtask

    task automatic test_result_backpressure();
        tx_idle_en = 1'b0;
        set_regs({$urandom, $urandom} | 64'h1, '1, 32'h0, MIN_BLOCK + WORD_BYTES * 24, '1);
        lay_ent.delete();
        lay_ent.push_back(24);
        build_run(1'b0);
        hold_reqs++;
        send_run();
        settle();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_pause_mid_table();
        int half;
        build_run(1'b0);
        half = tw_q.size() / 2;
        foreach (tw_q[i]) begin
            if (i == half) settle();
            send_word(tw_q[i], te_q[i]);
        end
        settle();
    endtask

    task automatic test_random_tables(input int n_target, input bit idle_en);
        int                first, nblk, n, tsz, big;
        logic [ADJ_W-1:0]  adj;
        logic [ADDR_W-1:0] img, toff, tsize, dir;
        tx_idle_en = idle_en;
        rx_idle_en = idle_en;
        first = n_words;
        while (n_words - first < n_target) begin
            lay_ent.delete();
            tsz  = 0;
            big  = 0;
            nblk = $urandom_range(4, 1);
            repeat (nblk) begin
                n = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 0) : $urandom_range(8, 0);
                lay_ent.push_back(n);
                tsz += MIN_BLOCK + WORD_BYTES * n;
                if (MIN_BLOCK + WORD_BYTES * n > big) big = MIN_BLOCK + WORD_BYTES * n;
            end
            case ($urandom_range(11, 0))
                0:       adj = '0;
                1, 2:    adj = '1;
                3:       adj = 64'h1;
                default: adj = {$urandom, $urandom};
            endcase
            toff  = ($urandom_range(2, 0) == 0) ? 32'h0 : $urandom_range(32'h0FFF_FFFF, 0);
            tsize = ($urandom_range(9, 0) == 0) ? $urandom_range(tsz, 0) : tsz;
            case ($urandom_range(5, 0))
                0, 1:    img = '1;
                2:       img = toff + tsz;   // the laid-out blocks end right at the image end
                default: img = $urandom | 32'h4000_0000;
            endcase
            case ($urandom_range(9, 0))
                0:       dir = big - WORD_BYTES;
                1, 2, 3: dir = big;
                default: dir = '1;
            endcase
            set_regs(adj, img, toff, tsize, dir);
            repeat ($urandom_range(4, 2)) begin
                build_run(1'b1);
                send_run();
            end
            settle();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rearm();
        r_adjust = '0; r_image = '0; r_toff = '0; r_tsize = '0; r_dir = '0;

        test_run_start();
        test_full_table();
        test_block_errors();
        test_result_backpressure();
        test_pause_mid_table();
        test_random_tables(200, 1'b1);
        test_random_tables(80, 1'b0);
        test_random_tables(200, 1'b1);

        $display("run: %0d table words over %0d register settings, %0d result beats checked",
                 n_words, n_settings, n_beats);
        $display("beats: high16 %0d low16 %0d add32 %0d add64 %0d done %0d error %0d",
                 kind_seen[KIND_HIGH16], kind_seen[KIND_LOW16], kind_seen[KIND_ADD32],
                 kind_seen[KIND_ADD64], kind_seen[KIND_DONE], kind_seen[KIND_ERROR]);
        if (n_fail == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
